// File: rtl/stq_pkg.sv
// Shared types, codes and the wrap-aware time compare for the sorted timer queue.
package stq_pkg;

   localparam int TIMERS_DEFAULT = 16;
   localparam int ID_W           = 4;
   localparam int ID_COUNT       = 16;
   localparam int TIME_W         = 32;
   localparam int CMD_W          = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_START  = 2'd0,
      CMD_STOP   = 2'd1,
      CMD_CHECK  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NONE   = 2'd0,
      OP_INSERT = 2'd1,
      OP_REMOVE = 2'd2,
      OP_POP    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_STATUS
   } state_type;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   tid;
      logic [TIME_W-1:0] expiry;
   } entry_type;

   // a is earlier than b when (a - b) mod 2^32 has its top bit set
   function automatic logic earlier(input logic [TIME_W-1:0] a,
                                    input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

endpackage

// File: rtl/stq_cell.sv
// One queue cell: holds a timer entry and shifts toward its neighbors on insert, remove or pop.
module stq_cell
   import stq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  op_type            op,
   input  logic [TIME_W-1:0] new_time,
   input  logic [ID_W-1:0]   new_id,
   input  entry_type         left,
   input  entry_type         right,
   input  logic              found_in,
   output entry_type         entry,
   output logic              found_out
);

   logic              valid_ff;
   logic [ID_W-1:0]   tid_ff;
   logic [TIME_W-1:0] expiry_ff;
   entry_type         entry_in;
   logic              hit;

   assign entry = '{valid: valid_ff, tid: tid_ff, expiry: expiry_ff};

   always_comb begin
      unique case (op)
         OP_INSERT: hit = !valid_ff || earlier(new_time, expiry_ff);
         OP_REMOVE: hit = valid_ff && (tid_ff == new_id);
         OP_NONE,
         OP_POP:    hit = 1'b0;
      endcase
   end

   assign found_out = found_in || hit;

   always_comb begin
      entry_in = entry;
      unique case (op)
         OP_INSERT: begin
            if (found_in) begin
               entry_in = left;
            end else if (hit) begin
               entry_in = '{valid: 1'b1, tid: new_id, expiry: new_time};
            end
         end
         OP_REMOVE,
         OP_POP: begin
            if (found_in || hit) begin
               entry_in = right;
            end
         end
         OP_NONE: entry_in = entry;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= entry_in.valid;
      end
      tid_ff    <= entry_in.tid;
      expiry_ff <= entry_in.expiry;
   end

endmodule

// File: rtl/sorted_timer_queue.sv
// Sorted timer queue: control, running flags, result register and the chain of cells.
// Keeps up to TIMERS timers in a chain of cells ordered by wrap-aware expiry time (a is
// earlier than b when bit 31 of a - b is set); equal times keep arrival order. One item
// is taken at a time. Start and stop shift the whole chain at once in ST_RUN; ST_STATUS
// then loads the status item into the result register once it is free, and the next item
// is taken back in ST_IDLE. A check pops one expired head per cycle while the result
// register is free, as each notice passes through that single result register; a
// stalled rsp_ready holds the pops. Every item ends with one status item carrying last = 1.
module sorted_timer_queue
   import stq_pkg::*;
#(
   parameter int TIMERS = TIMERS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [ID_W-1:0]   req_timer_id,
   input  logic [TIME_W-1:0] req_expiry_time,
   input  logic [TIME_W-1:0] req_now,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [ID_W-1:0]   rsp_expired_id,
   output logic [TIME_W-1:0] rsp_compare_time,
   output logic              rsp_compare_enable,
   output logic              rsp_error,
   output logic              rsp_last
);

   state_type         state_ff, state_in;
   cmd_type           cmd_ff;
   logic [ID_W-1:0]   tid_ff;
   logic [TIME_W-1:0] exp_ff;
   logic [TIME_W-1:0] now_ff;
   logic              err_ff;
   logic [ID_COUNT-1:0] running_ff;

   logic              rsp_valid_ff;
   logic              rsp_kind_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic              rsp_en_ff;
   logic              rsp_err_ff;
   logic              rsp_last_ff;

   op_type            chain_op;
   entry_type         cells [TIMERS];
   logic              found [TIMERS+1];
   logic [TIMERS-1:0] valid_vec;
   entry_type         head;
   logic              full;
   logic              head_expired;
   logic              slot_free;
   logic              accept;

   logic              run_set;
   logic              run_clr;
   logic [ID_W-1:0]   run_idx;
   logic              err_set;
   logic              load_notice;
   logic              load_status;

   assign head         = cells[0];
   assign full         = cells[TIMERS-1].valid;
   assign head_expired = head.valid && !earlier(now_ff, head.expiry);
   assign slot_free    = !rsp_valid_ff || rsp_ready;
   assign req_ready    = (state_ff == ST_IDLE);
   assign accept       = req_valid && req_ready;

   // cell chain
   assign found[0] = (chain_op == OP_POP);

   for (genvar i = 0; i < TIMERS; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      if (i == 0) begin : g_first
         assign left_e = '0;
      end else begin : g_mid_l
         assign left_e = cells[i-1];
      end
      if (i == TIMERS - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_mid_r
         assign right_e = cells[i+1];
      end
      assign valid_vec[i] = cells[i].valid;

      stq_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .op        (chain_op),
         .new_time  (exp_ff),
         .new_id    (tid_ff),
         .left      (left_e),
         .right     (right_e),
         .found_in  (found[i]),
         .entry     (cells[i]),
         .found_out (found[i+1])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!(cmd_ff == CMD_CHECK && head_expired)) begin
               state_in = ST_STATUS;
            end
         end
         ST_STATUS: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      chain_op    = OP_NONE;
      run_set     = 1'b0;
      run_clr     = 1'b0;
      run_idx     = tid_ff;
      err_set     = 1'b0;
      load_notice = 1'b0;
      load_status = 1'b0;
      unique case (state_ff)
         ST_RUN: begin
            unique case (cmd_ff)
               CMD_START: begin
                  if (running_ff[tid_ff] || full) begin
                     err_set = 1'b1;
                  end else begin
                     chain_op = OP_INSERT;
                     run_set  = 1'b1;
                  end
               end
               CMD_STOP: begin
                  if (running_ff[tid_ff]) begin
                     chain_op = OP_REMOVE;
                     run_clr  = 1'b1;
                  end
               end
               CMD_CHECK: begin
                  if (head_expired && slot_free) begin
                     chain_op    = OP_POP;
                     run_clr     = 1'b1;
                     run_idx     = head.tid;
                     load_notice = 1'b1;
                  end
               end
               CMD_UNUSED: chain_op = OP_NONE;
            endcase
         end
         ST_STATUS: load_status = slot_free;
         ST_IDLE:   chain_op = OP_NONE;
         default:   chain_op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         running_ff <= '0;
         err_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (run_set) begin
            running_ff[run_idx] <= 1'b1;
         end else if (run_clr) begin
            running_ff[run_idx] <= 1'b0;
         end
         if (accept) begin
            err_ff <= 1'b0;
         end else if (err_set) begin
            err_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_type'(req_cmd);
         tid_ff <= req_timer_id;
         exp_ff <= req_expiry_time;
         now_ff <= req_now;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_notice || load_status) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_notice) begin
         rsp_kind_ff <= KIND_NOTICE;
         rsp_id_ff   <= head.tid;
         rsp_time_ff <= head.expiry;
         rsp_en_ff   <= 1'b0;
         rsp_err_ff  <= 1'b0;
         rsp_last_ff <= 1'b0;
      end else if (load_status) begin
         rsp_kind_ff <= KIND_STATUS;
         rsp_id_ff   <= '0;
         rsp_time_ff <= head.valid ? head.expiry : '0;
         rsp_en_ff   <= head.valid;
         rsp_err_ff  <= err_ff;
         rsp_last_ff <= 1'b1;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = rsp_kind_ff;
   assign rsp_expired_id     = rsp_id_ff;
   assign rsp_compare_time   = rsp_time_ff;
   assign rsp_compare_enable = rsp_en_ff;
   assign rsp_error          = rsp_err_ff;
   assign rsp_last           = rsp_last_ff;

`ifndef SYNTHESIS
   a_packed: assert property (@(posedge clock) disable iff (reset)
      (valid_vec & (valid_vec + 1'b1)) == '0)
      else $error("occupied cells are not packed at the head");

   a_running_count: assert property (@(posedge clock) disable iff (reset)
      $countones(running_ff) == $countones(valid_vec))
      else $error("running timers disagree with occupied cells");

   a_notice_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_kind_ff == KIND_NOTICE) |-> !rsp_last_ff)
      else $error("expiry notice marked as last");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN))
      else $error("accepted item did not start execution");
`endif

endmodule
